// ===== hw/rtl/ppd_pkg.sv =====
// Shared types and constants for the polygon presence detector.
// No dependencies; used by ppd_cell, ppd_tester and polygon_presence_detector.
`default_nettype none
package ppd_pkg;

    localparam int COORD_W       = 32;
    localparam int COUNT_W       = 7;
    localparam int INDEX_W       = 6;
    localparam int SLOT_LIMIT    = 2 ** INDEX_W;
    localparam int MAX_EDGES_DEF = 64;

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } edge_t;

    typedef struct packed {
        logic valid;
        logic live;
        logic first;
        logic last;
    } tst_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppd_cell.sv =====
// One edge store cell of the rotating edge ring.
// Depends on ppd_pkg for edge_t.
`default_nettype none
module ppd_cell (
    input  wire logic           clk,
    input  wire logic           shift,
    input  wire logic           we,
    input  wire ppd_pkg::edge_t wdata,
    input  wire ppd_pkg::edge_t nbr,
    output ppd_pkg::edge_t      q
);
    import ppd_pkg::*;

    edge_t edge_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            edge_reg <= wdata;
        end
        else if (shift)
        begin
            edge_reg <= nbr;
        end
    end

    assign q = edge_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ppd_tester.sv =====
// Three-stage crossing tester fed one edge per cycle from the ring head.
// Depends on ppd_pkg for edge_t and tst_req_t.
`default_nettype none
module ppd_tester (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ppd_pkg::tst_req_t                  req,
    input  wire ppd_pkg::edge_t                     edge_in,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] px,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] py,
    output logic                                    done,
    output logic                                    odd
);
    import ppd_pkg::*;

    // stage 1: differences and straddle check
    logic                    v1_reg, first1_reg, last1_reg, cross1_reg;
    logic signed [COORD_W:0] a_reg, dy_reg, b_reg, c_reg;
    // stage 2: products
    logic                        v2_reg, first2_reg, last2_reg, cross2_reg, pos2_reg;
    logic signed [2*COORD_W+1:0] lhs_reg, rhs_reg;
    logic signed [2*COORD_W+1:0] lhs_next, rhs_next;
    // stage 3: parity
    logic parity_reg, done_reg;
    logic toggle, parity_next;

    always_comb
    begin
        lhs_next = a_reg * dy_reg;
        rhs_next = b_reg * c_reg;
    end

    always_comb
    begin
        toggle      = cross2_reg && (pos2_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg));
        parity_next = (first2_reg ? 1'b0 : parity_reg) ^ toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            done_reg   <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg && last2_reg;
            if (v2_reg)
            begin
                parity_reg <= parity_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= req.first;
        last1_reg  <= req.last;
        cross1_reg <= req.live && ((edge_in.y1 > py) != (edge_in.y2 > py));
        a_reg      <= (COORD_W+1)'(px) - (COORD_W+1)'(edge_in.x1);
        dy_reg     <= (COORD_W+1)'(edge_in.y2) - (COORD_W+1)'(edge_in.y1);
        b_reg      <= (COORD_W+1)'(edge_in.x2) - (COORD_W+1)'(edge_in.x1);
        c_reg      <= (COORD_W+1)'(py) - (COORD_W+1)'(edge_in.y1);

        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        cross2_reg <= cross1_reg;
        pos2_reg   <= !dy_reg[COORD_W];
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
    end

    assign done = done_reg;
    assign odd  = parity_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/polygon_presence_detector.sv =====
// Polygon presence detector: edges are held in a rotating ring of cells that
// feeds a crossing tester at its head. A contact point rotates the whole ring
// once whatever edge_count holds, and its result passes through the three
// tester stages. A presence item is emitted only when the frame result
// differs from the last one reported. Depends on ppd_pkg, ppd_cell and
// ppd_tester.
`default_nettype none
module polygon_presence_detector #(
    parameter int MAX_EDGES = ppd_pkg::MAX_EDGES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         op,
    input  wire logic [ppd_pkg::INDEX_W-1:0]        edge_index,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] ax,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] ay,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] bx,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] by,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [ppd_pkg::COORD_W-1:0] point_y,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    presence,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ppd_pkg::COUNT_W-1:0]        cfg_data
);
    import ppd_pkg::*;

    localparam int KW = $clog2(MAX_EDGES);
    localparam int CW = (KW + 1 > COUNT_W) ? KW + 1 : COUNT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT} state_t;

    state_t                    state_reg;
    logic [KW-1:0]             k_reg;
    logic [COUNT_W-1:0]        edge_count_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic                      frame_hit_reg, reported_reg;
    logic                      out_valid_reg, presence_reg;

    logic      accept, wr_edge, emit;
    edge_t     wdata;
    edge_t     ring_q [MAX_EDGES];
    tst_req_t  req;
    logic      tst_done, tst_inside;
    logic      last_k;

    assign accept  = in_valid && !in_stall;
    assign wr_edge = accept && (op == OP_EDGE);
    assign emit    = accept && (op == OP_END) && (frame_hit_reg != reported_reg);
    assign wdata   = '{x1: ax, y1: ay, x2: bx, y2: by};
    assign last_k  = (k_reg == KW'(MAX_EDGES - 1));

    // hold input while busy, or hold an end item while a result waits at a stalled output
    assign in_stall  = (state_reg != ST_IDLE) || (op == OP_END && out_valid_reg && out_stall);
    assign cfg_ready = 1'b1;

    genvar i;
    generate
        for (i = 0; i < MAX_EDGES; i++)
        begin : g_ring
            localparam int NXT = (i + 1) % MAX_EDGES;
            logic we;
            if (i < SLOT_LIMIT)
            begin : g_wr
                assign we = wr_edge && (edge_index == INDEX_W'(i));
            end
            else
            begin : g_nowr
                assign we = 1'b0;
            end
            ppd_cell u_cell (
                .clk   (clk),
                .shift (state_reg == ST_SCAN),
                .we    (we),
                .wdata (wdata),
                .nbr   (ring_q[NXT]),
                .q     (ring_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        req.valid = (state_reg == ST_SCAN);
        req.live  = CW'(k_reg) < CW'(edge_count_reg);
        req.first = (k_reg == '0);
        req.last  = last_k;
    end

    ppd_tester u_tester (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .edge_in (ring_q[0]),
        .px      (px_reg),
        .py      (py_reg),
        .done    (tst_done),
        .odd     (tst_inside)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            edge_count_reg <= '0;
            frame_hit_reg  <= 1'b0;
            reported_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            presence_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                edge_count_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op == OP_POINT)
                    begin
                        state_reg <= ST_SCAN;
                        k_reg     <= '0;
                    end
                    else if (accept && op == OP_END)
                    begin
                        frame_hit_reg <= 1'b0;
                        if (frame_hit_reg != reported_reg)
                        begin
                            reported_reg <= frame_hit_reg;
                            presence_reg <= frame_hit_reg;
                        end
                    end
                end
                ST_SCAN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (last_k)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (tst_done)
                    begin
                        state_reg <= ST_IDLE;
                        if (tst_inside)
                        begin
                            frame_hit_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_POINT)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign presence  = presence_reg;

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        tst_done |-> state_reg == ST_WAIT)
        else $error("tester finished outside wait state");
    a_point_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_POINT) |=> (state_reg == ST_SCAN && k_reg == '0))
        else $error("point item did not start a scan");
    a_result_changes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (presence_reg == reported_reg))
        else $error("reported presence out of step with emitted item");
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken during scan");
`endif

endmodule
`default_nettype wire

// ===== test/tb_polygon_presence_detector.sv =====
// Self-checking testbench for polygon_presence_detector: edge tables, contact
// points and frame ends are driven through a stalling port and checked
// against an in-bench crossing-number predictor. Depends on ppd_pkg and the RTL.
`timescale 1ns / 1ps
module tb_polygon_presence_detector;
    import ppd_pkg::*;

    localparam int NEDGE   = MAX_EDGES_DEF;
    localparam int SETTLE  = NEDGE + 24;
    localparam int LIMIT   = 600000;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

    typedef struct {
        logic [1:0]         op;
        logic [5:0]         idx;
        logic signed [31:0] ax, ay, bx, by, px, py;
    } item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid, in_stall, out_valid, out_stall, presence;
    logic cfg_valid, cfg_ready;
    logic [COUNT_W-1:0] cfg_data;
    logic [1:0] op;
    logic [5:0] edge_index;
    logic signed [31:0] ax, ay, bx, by, point_x, point_y;

    // predictor state
    logic signed [31:0] tbl_x1 [NEDGE];
    logic signed [31:0] tbl_y1 [NEDGE];
    logic signed [31:0] tbl_x2 [NEDGE];
    logic signed [31:0] tbl_y2 [NEDGE];
    bit   written [NEDGE];
    bit   hit_in_frame, last_presence;
    int   count_used;

    item_t pending [$];
    bit    presence_due [$];
    int    errors, cycles, made, in_gap, out_gap;
    bit    quiet;

    polygon_presence_detector i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .edge_index(edge_index),
        .ax(ax), .ay(ay), .bx(bx), .by(by), .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_stall(out_stall), .presence(presence),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit inside_polygon(logic signed [31:0] px, logic signed [31:0] py);
        logic signed [67:0] x1, y1, x2, y2, dy, lhs, rhs, wx, wy;
        int n;
        bit in;
        n = (count_used > NEDGE) ? NEDGE : count_used;
        in = 1'b0;
        wx = px;
        wy = py;
        for (int k = 0; k < n; k++)
        begin
            x1 = tbl_x1[k]; y1 = tbl_y1[k]; x2 = tbl_x2[k]; y2 = tbl_y2[k];
            if ((y1 > wy) != (y2 > wy))
            begin
                dy  = y2 - y1;
                lhs = (wx - x1) * dy;
                rhs = (x2 - x1) * (wy - y1);
                if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
                    in = !in;
            end
        end
        return in;
    endfunction

    task automatic apply_item(item_t it);
        case (it.op)
            OP_EDGE:
            begin
                tbl_x1[it.idx] = it.ax; tbl_y1[it.idx] = it.ay;
                tbl_x2[it.idx] = it.bx; tbl_y2[it.idx] = it.by;
                written[it.idx] = 1'b1;
            end
            OP_POINT:
                if (inside_polygon(it.px, it.py))
                    hit_in_frame = 1'b1;
            OP_END:
            begin
                if (hit_in_frame != last_presence)
                begin
                    last_presence = hit_in_frame;
                    presence_due.push_back(hit_in_frame);
                end
                hit_in_frame = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic report(string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // driver: hold a stalled item, otherwise advance or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_gap     <= 0;
            op         <= OP_NONE;
            edge_index <= '0;
            ax         <= '0;
            ay         <= '0;
            bx         <= '0;
            by         <= '0;
            point_x    <= '0;
            point_y    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_item('{op, edge_index, ax, ay, bx, by, point_x, point_y});
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    item_t it;
                    it = pending.pop_front();
                    op <= it.op; edge_index <= it.idx;
                    ax <= it.ax; ay <= it.ay; bx <= it.bx; by <= it.by;
                    point_x <= it.px; point_y <= it.py;
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        in_gap <= $urandom_range(1, 15);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each item against the oldest due presence
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (presence_due.size() == 0)
                    report("presence item with none due");
                else if (presence !== presence_due.pop_front())
                    report($sformatf("presence %b wrong", presence));
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap   <= $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL polygon_presence_detector");
            $finish;
        end
    end

    function automatic item_t rand_item(logic [1:0] o);
        item_t it;
        it.op = o; it.idx = 6'($urandom());
        it.ax = $urandom(); it.ay = $urandom(); it.bx = $urandom(); it.by = $urandom();
        it.px = $urandom(); it.py = $urandom();
        return it;
    endfunction

    task automatic push_edge(int slot, logic signed [31:0] x1, logic signed [31:0] y1,
                             logic signed [31:0] x2, logic signed [31:0] y2);
        item_t it;
        it = rand_item(OP_EDGE);
        it.idx = 6'(slot); it.ax = x1; it.ay = y1; it.bx = x2; it.by = y2;
        pending.push_back(it);
        made++;
    endtask

    task automatic push_point(logic signed [31:0] x, logic signed [31:0] y);
        item_t it;
        it = rand_item(OP_POINT);
        it.px = x; it.py = y;
        pending.push_back(it);
        made++;
    endtask

    task automatic push_op(logic [1:0] o);
        pending.push_back(rand_item(o));
        made++;
    endtask

    // drain everything, then allow a full ring rotation for trailing points
    task automatic settle();
        while (pending.size() > 0 || in_valid || presence_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(int want);
        int prefix;
        prefix = 0;
        while (prefix < NEDGE && written[prefix])
            prefix++;
        // never let the tester reach a slot that was never written
        if ((want > NEDGE ? NEDGE : want) > prefix)
            want = prefix;
        cfg_data  <= COUNT_W'(want);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        count_used = want;
    endtask

    initial
    begin
        int n, cx, cy, r, frames;
        logic signed [31:0] vx [NEDGE];
        logic signed [31:0] vy [NEDGE];
        cfg_valid = 1'b0; cfg_data = '0;
        made = 0; quiet = 1'b0;
        count_used = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full-range square, ignored items, empty frame with no edges
        write_count(0);
        push_edge(0, CMIN, CMIN, CMAX, CMIN);
        push_edge(1, CMAX, CMIN, CMAX, CMAX);
        push_edge(2, CMAX, CMAX, CMIN, CMAX);
        push_edge(3, CMIN, CMAX, CMIN, CMIN);
        push_edge(63, CMAX, CMIN, CMIN, CMAX);
        push_op(OP_NONE);
        push_point(0, 0);
        push_op(OP_END);
        settle();
        write_count(4);
        push_point(0, 0);
        push_point(CMIN, CMIN);
        push_point(CMAX - 1, CMAX - 1);
        push_op(OP_NONE);
        push_op(OP_END);
        push_point(CMAX, CMAX);
        push_point(CMIN, CMAX);
        push_op(OP_END);
        push_op(OP_END);
        settle();

        // random: polygons of random shape, frames of points around them
        while (made < 600)
        begin
            quiet = (made > 500);
            n = ($urandom_range(0, 9) == 0) ? NEDGE : $urandom_range(3, 8);
            r  = 1 << $urandom_range(4, 28);
            cx = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
            cy = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
            for (int i = 0; i < n; i++)
            begin
                vx[i] = cx + $signed($urandom_range(0, 2 * r)) - r;
                vy[i] = cy + $signed($urandom_range(0, 2 * r)) - r;
            end
            for (int i = 0; i < n; i++)
                push_edge(i, vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n]);
            settle();
            case ($urandom_range(0, 7))
                0: write_count(0);
                1: write_count(n == NEDGE ? 127 : n - 1);
                default: write_count(n);
            endcase
            frames = $urandom_range(2, 6);
            for (int f = 0; f < frames; f++)
            begin
                for (int p = $urandom_range(0, 4); p > 0; p--)
                begin
                    case ($urandom_range(0, 9))
                        0: push_point($urandom(), $urandom());
                        1: push_op(OP_NONE);
                        2: push_edge($urandom_range(0, NEDGE - 1), $urandom(), $urandom(),
                                     $urandom(), $urandom());
                        3: push_point(vx[0], vy[0]);
                        default: push_point(cx + $signed($urandom_range(0, 2 * r)) - r,
                                            cy + $signed($urandom_range(0, 2 * r)) - r);
                    endcase
                end
                push_op(OP_END);
            end
        end
        settle();

        if (errors == 0 && presence_due.size() == 0)
            $display("PASS polygon_presence_detector");
        else
            $display("FAIL polygon_presence_detector");
        $finish;
    end

endmodule
